FILE: hdl/bvob_pkg.sv
// Package with the word types and constants of the box versus oriented box overlap test.
`timescale 1ns / 1ps
`default_nettype none
package bvob_pkg;

  localparam int INDEX_W   = 16;
  localparam int COORD_W   = 32;
  localparam int HALF_W    = 31;
  localparam int COMP_W    = 16;
  localparam int AXIS_W    = 3 * COMP_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  typedef struct packed {
    logic [INDEX_W-1:0]        item_index;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [HALF_W-1:0]         half_size_a;
    logic [HALF_W-1:0]         half_size_b;
    logic [HALF_W-1:0]         half_size_c;
    logic [AXIS_W-1:0]         axis_a;
    logic [AXIS_W-1:0]         axis_b;
    logic [AXIS_W-1:0]         axis_c;
    logic                      batch_end;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] hit_index;
    logic               batch_done;
  } out_word_t;

endpackage
`default_nettype wire

FILE: hdl/bvob_in_if.sv
// Handshake interface that carries oriented box words into the overlap test.
`timescale 1ns / 1ps
`default_nettype none
interface bvob_in_if;
  import bvob_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/bvob_out_if.sv
// Handshake interface that carries result words out of the overlap test.
`timescale 1ns / 1ps
`default_nettype none
interface bvob_out_if;
  import bvob_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/box_vs_oriented_box_overlap.sv
// Top level of the overlap test of a query box against a stream of oriented boxes.
// An accepted word passes through stages one, two and three and then into the result register.
// Throughput: one word per cycle while the output is not stalled, set by the four-stage pipeline
// (component absolute values, multipliers, radius adders, compare and output register).
// A stalled output holds the pipeline; empty stages still fill behind it.
// Reset clears all stage valid bits and sets the six bound registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module box_vs_oriented_box_overlap #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bvob_in_if.sink                              in_box,
  bvob_out_if.source                           out_res,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bvob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bvob_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bvob_pkg::*;

  localparam int IDX_W  = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = HALF_W + COMP_W - 1;
  localparam int RAD_W  = PROD_W + 2;
  localparam int CMP_W  = RAD_W + 1;
  localparam int FRAC_SHIFT = COMP_W - 2;

  logic signed [COORD_W-1:0] bmin_r [3];
  logic signed [COORD_W-1:0] bmax_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        bmin_r[k] <= '0;
        bmax_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: bmin_r[0] <= cfg_wdata[COORD_W-1:0];
        REG_BOX_MIN_Y: bmin_r[1] <= cfg_wdata[COORD_W-1:0];
        REG_BOX_MIN_Z: bmin_r[2] <= cfg_wdata[COORD_W-1:0];
        REG_BOX_MAX_X: bmax_r[0] <= cfg_wdata[COORD_W-1:0];
        REG_BOX_MAX_Y: bmax_r[1] <= cfg_wdata[COORD_W-1:0];
        REG_BOX_MAX_Z: bmax_r[2] <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  logic rdy1, rdy2, rdy3, rdy4;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  assign rdy4 = !s4_v_r || out_res.ready;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_box.ready = rdy1;

  logic signed [COORD_W-1:0] ctr [3];
  logic [HALF_W-1:0]         half [3];
  logic [AXIS_W-1:0]         axis [3];

  assign ctr[0]  = in_box.data.center_x;
  assign ctr[1]  = in_box.data.center_y;
  assign ctr[2]  = in_box.data.center_z;
  assign half[0] = in_box.data.half_size_a;
  assign half[1] = in_box.data.half_size_b;
  assign half[2] = in_box.data.half_size_c;
  assign axis[0] = in_box.data.axis_a;
  assign axis[1] = in_box.data.axis_b;
  assign axis[2] = in_box.data.axis_c;

  // Stage one: absolute axis components and center offsets from both bounds.
  logic [COMP_W-1:0]        s1_abs_r [3][3];
  logic [HALF_W-1:0]        s1_half_r [3];
  logic signed [DIFF_W-1:0] s1_dmax_r [3];
  logic signed [DIFF_W-1:0] s1_dmin_r [3];
  logic [IDX_W-1:0]         s1_idx_r;
  logic                     s1_be_r;

  logic [COMP_W-1:0]        abs_nxt [3][3];
  logic signed [DIFF_W-1:0] dmax_nxt [3];
  logic signed [DIFF_W-1:0] dmin_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        abs_nxt[i][k] = axis[i][COMP_W*k+COMP_W-1] ?
                        (~axis[i][COMP_W*k +: COMP_W] + COMP_W'(1)) :
                        axis[i][COMP_W*k +: COMP_W];
      end
    end
    for (int k = 0; k < 3; k++) begin
      dmax_nxt[k] = {ctr[k][COORD_W-1], ctr[k]} - {bmax_r[k][COORD_W-1], bmax_r[k]};
      dmin_nxt[k] = {bmin_r[k][COORD_W-1], bmin_r[k]} - {ctr[k][COORD_W-1], ctr[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_box.valid;
    end
    if (rdy1 && in_box.valid) begin
      s1_abs_r  <= abs_nxt;
      s1_half_r <= half;
      s1_dmax_r <= dmax_nxt;
      s1_dmin_r <= dmin_nxt;
      s1_idx_r  <= in_box.data.item_index[IDX_W-1:0];
      s1_be_r   <= in_box.data.batch_end;
    end
  end

  // Stage two: nine products of half size and absolute component.
  logic [PROD_W-1:0]        s2_prod_r [3][3];
  logic signed [DIFF_W-1:0] s2_dmax_r [3];
  logic signed [DIFF_W-1:0] s2_dmin_r [3];
  logic [IDX_W-1:0]         s2_idx_r;
  logic                     s2_be_r;

  logic [PROD_W-1:0] prod_full [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        prod_full[k][i] = {{(COMP_W-1){1'b0}}, s1_half_r[i]} *
                          {{(HALF_W-1){1'b0}}, s1_abs_r[i][k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
    if (rdy2 && s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          s2_prod_r[k][i] <= prod_full[k][i];
        end
      end
      s2_dmax_r <= s1_dmax_r;
      s2_dmin_r <= s1_dmin_r;
      s2_idx_r  <= s1_idx_r;
      s2_be_r   <= s1_be_r;
    end
  end

  // Stage three: projected radius on each world axis.
  logic [RAD_W-1:0]         s3_rad_r [3];
  logic signed [DIFF_W-1:0] s3_dmax_r [3];
  logic signed [DIFF_W-1:0] s3_dmin_r [3];
  logic [IDX_W-1:0]         s3_idx_r;
  logic                     s3_be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
    if (rdy3 && s2_v_r) begin
      for (int k = 0; k < 3; k++) begin
        s3_rad_r[k] <= {2'b00, s2_prod_r[k][0]} + {2'b00, s2_prod_r[k][1]} +
                       {2'b00, s2_prod_r[k][2]};
      end
      s3_dmax_r <= s2_dmax_r;
      s3_dmin_r <= s2_dmin_r;
      s3_idx_r  <= s2_idx_r;
      s3_be_r   <= s2_be_r;
    end
  end

  // Stage four: strict compares against the radius, registered as the result word.
  logic signed [CMP_W-1:0] lhs_max [3];
  logic signed [CMP_W-1:0] lhs_min [3];
  logic signed [CMP_W-1:0] rhs [3];
  logic                    hit_nxt;

  always_comb begin
    hit_nxt = 1'b1;
    for (int k = 0; k < 3; k++) begin
      lhs_max[k] = {{(CMP_W-DIFF_W-FRAC_SHIFT){s3_dmax_r[k][DIFF_W-1]}}, s3_dmax_r[k],
                    {(FRAC_SHIFT){1'b0}}};
      lhs_min[k] = {{(CMP_W-DIFF_W-FRAC_SHIFT){s3_dmin_r[k][DIFF_W-1]}}, s3_dmin_r[k],
                    {(FRAC_SHIFT){1'b0}}};
      rhs[k]     = {1'b0, s3_rad_r[k]};
      hit_nxt    = hit_nxt && (lhs_max[k] < rhs[k]) && (lhs_min[k] < rhs[k]);
    end
  end

  logic             s4_hit_r;
  logic [IDX_W-1:0] s4_idx_r;
  logic             s4_be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (rdy4) begin
      s4_v_r <= s3_v_r;
    end
    if (rdy4 && s3_v_r) begin
      s4_hit_r <= hit_nxt;
      s4_idx_r <= s3_idx_r;
      s4_be_r  <= s3_be_r;
    end
  end

  assign out_res.valid           = s4_v_r;
  assign out_res.data.hit        = s4_hit_r;
  assign out_res.data.hit_index  = INDEX_W'(s4_idx_r);
  assign out_res.data.batch_done = s4_be_r;

  // An accepted word always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_box.valid && in_box.ready |=> s1_v_r)
    else $error("accepted word did not reach stage one");

  // The input side only blocks when every stage holds a word.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_box.ready |-> s1_v_r && s2_v_r && s3_v_r && s4_v_r && !out_res.ready)
    else $error("input blocked with an empty stage");

  // A word in stage three waits while the result register is stalled.
  a_s3_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !out_res.ready && s3_v_r |=> s3_v_r && $stable(s3_idx_r) && $stable(s3_be_r))
    else $error("stage three word lost during stall");

  // A stage that moves its word on hands it to the next stage.
  a_s2_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && rdy3 |=> s3_v_r && (s3_idx_r == $past(s2_idx_r)))
    else $error("stage two word not passed on");
endmodule
`default_nettype wire
